### hdl/uvsg_pkg.sv
// uvsg_pkg: widths, register codes, CORDIC angle table and saturation helpers
// for the UV sphere vertex generator. No dependencies.
`default_nettype none

package uvsg_pkg;

  // field and register widths
  localparam int RADW      = 16;
  localparam int SUBW      = 11;
  localparam int ROWW      = 11;
  localparam int COLW      = 12;
  localparam int CFGW      = 16;
  localparam int CFG_IDXW  = 2;
  localparam int POSW      = 17;
  localparam int UNITW     = 16;
  localparam int TEXW      = 17;

  // divider: angle-lane numerator is index * 2^31 plus half the divisor
  localparam int ANG_FRAC  = 31;
  localparam int NUMW      = COLW + ANG_FRAC;
  localparam int REMW      = SUBW;
  localparam int ANGW      = 32;

  // CORDIC datapath width (Q2.30 plus headroom)
  localparam int CW        = 34;
  localparam int MAX_CORDIC_STAGES = 24;

  localparam int MIN_SUBDIVISION     = 2;
  localparam int DEF_MAX_SUBDIVISION = 1024;
  localparam int DEF_CORDIC_STAGES   = 16;

  localparam logic [RADW-1:0] RADIUS_RESET = 16'd256;
  localparam logic [SUBW-1:0] SUBDIV_RESET = 11'd16;

  // 1/K in Q2.30
  localparam logic [ANGW-1:0] CORDIC_X0 = 32'h26DD3B6A;

  typedef enum logic [CFG_IDXW-1:0] {
    REG_RADIUS      = 2'd0,
    REG_SUBDIVISION = 2'd1
  } cfg_reg_t;

  // atan(2^-i) as binary angle, 2^32 per turn
  localparam logic [ANGW-1:0] ATAN_BAM [MAX_CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // clamp to +-1.0 in Q2.14
  function automatic logic signed [UNITW-1:0] sat_unit(input logic signed [19:0] v);
    logic signed [UNITW-1:0] res;
    if (v > 20'sd16384) res = 16'sd16384;
    else if (v < -20'sd16384) res = -16'sd16384;
    else res = v[UNITW-1:0];
    return res;
  endfunction

  // clamp to +-65535 in Q9.8
  function automatic logic signed [POSW-1:0] sat_pos(input logic signed [19:0] v);
    logic signed [POSW-1:0] res;
    if (v > 20'sd65535) res = 17'sd65535;
    else if (v < -20'sd65535) res = -17'sd65535;
    else res = v[POSW-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/uv_sphere_vertex_generator.sv
// Pipeline: NUMW (43) divider cells, 1 reduction stage, CORDIC_STAGES CORDIC cells and 4 output stages.
// Throughput: one vertex per clock while the output is not stalled.
// The whole chain advances together; it holds only while a finished beat sits stalled.
// Reset (rst_n low, synchronous): all valid bits clear, radius = 1.0, subdivision = 16.
// uv_sphere_vertex_generator: top level; divider cell chain, CORDIC cell chain and
// output arithmetic. Depends on uvsg_pkg, uvsg_div_cell, uvsg_cordic_cell.
`default_nettype none

module uv_sphere_vertex_generator #(
  parameter int MAX_SUBDIVISION = uvsg_pkg::DEF_MAX_SUBDIVISION,
  parameter int CORDIC_STAGES   = uvsg_pkg::DEF_CORDIC_STAGES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [uvsg_pkg::CFG_IDXW-1:0]        cfg_index,
  input  logic [uvsg_pkg::CFGW-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [uvsg_pkg::ROWW-1:0]            in_stack_row,
  input  logic [uvsg_pkg::COLW-1:0]            in_slice_column,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [uvsg_pkg::POSW-1:0]     out_position_x,
  output logic signed [uvsg_pkg::POSW-1:0]     out_position_y,
  output logic signed [uvsg_pkg::POSW-1:0]     out_position_z,
  output logic signed [uvsg_pkg::UNITW-1:0]    out_normal_x,
  output logic signed [uvsg_pkg::UNITW-1:0]    out_normal_y,
  output logic signed [uvsg_pkg::UNITW-1:0]    out_normal_z,
  output logic signed [uvsg_pkg::UNITW-1:0]    out_tangent_x,
  output logic signed [uvsg_pkg::UNITW-1:0]    out_tangent_z,
  output logic [uvsg_pkg::TEXW-1:0]            out_tex_u,
  output logic [uvsg_pkg::TEXW-1:0]            out_tex_v,
  output logic                                 out_clamped
);
  import uvsg_pkg::*;

  localparam int NC = (CORDIC_STAGES > MAX_CORDIC_STAGES) ? MAX_CORDIC_STAGES
                                                          : CORDIC_STAGES;
  localparam int LN_T = 0;   // theta angle
  localparam int LN_P = 1;   // phi angle
  localparam int LN_U = 2;   // tex u
  localparam int LN_V = 3;   // tex v
  localparam int NLANE = 4;

  typedef struct packed {
    logic            clamped;
    logic            neg_t;
    logic            neg_p;
    logic [TEXW-1:0] u;
    logic [TEXW-1:0] v;
  } side_t;

  // ---------------- configuration ----------------
  logic [RADW-1:0] radius_r;
  logic [SUBW-1:0] sub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      sub_r    <= SUBDIV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:      radius_r <= cfg_data[RADW-1:0];
        REG_SUBDIVISION: sub_r    <= cfg_data[SUBW-1:0];
        default:         ;
      endcase
    end
  end

  logic [SUBW-1:0] sub_eff;
  logic [SUBW-2:0] half;

  always_comb begin
    sub_eff = sub_r;
    if (sub_r < SUBW'(MIN_SUBDIVISION)) sub_eff = SUBW'(MIN_SUBDIVISION);
    else if (int'(sub_r) > MAX_SUBDIVISION) sub_eff = SUBW'(MAX_SUBDIVISION);
    half = sub_eff[SUBW-1:1];
  end

  // ---------------- flow control ----------------
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- index clamp and numerators ----------------
  logic [ROWW-1:0] row_c;
  logic [COLW-1:0] col_c;
  logic            clp_in;

  always_comb begin
    row_c  = in_stack_row;
    col_c  = in_slice_column;
    clp_in = 1'b0;
    if (in_stack_row > sub_eff) begin
      row_c  = sub_eff;
      clp_in = 1'b1;
    end
    if (in_slice_column > {sub_eff, 1'b0}) begin
      col_c  = {sub_eff, 1'b0};
      clp_in = 1'b1;
    end
  end

  // ---------------- divider cell chain ----------------
  logic [REMW-1:0] d_rem [NLANE][NUMW+1];
  logic [NUMW-1:0] d_num [NLANE][NUMW+1];
  logic [NUMW-1:0] d_quo [NLANE][NUMW+1];

  assign d_num[LN_T][0] = NUMW'({row_c, ANG_FRAC'(half)});
  assign d_num[LN_P][0] = NUMW'({col_c, ANG_FRAC'(half)});
  assign d_num[LN_U][0] = NUMW'({col_c, 15'(half)});
  assign d_num[LN_V][0] = NUMW'({row_c, 16'(half)});

  for (genvar l = 0; l < NLANE; l++) begin : g_lane_init
    assign d_rem[l][0] = '0;
    assign d_quo[l][0] = '0;
  end

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      uvsg_div_cell u_cell (
        .clk     (clk),
        .en      (adv),
        .divisor (sub_eff),
        .rem_i   (d_rem[l][k]),
        .num_i   (d_num[l][k]),
        .quo_i   (d_quo[l][k]),
        .rem_o   (d_rem[l][k+1]),
        .num_o   (d_num[l][k+1]),
        .quo_o   (d_quo[l][k+1])
      );
    end
  end

  // divider sideband
  logic [NUMW-1:0] dv_r;
  logic [NUMW-1:0] dclp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= {dv_r[NUMW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dclp_r <= {dclp_r[NUMW-2:0], clp_in};
  end

  // ---------------- range reduction ----------------
  logic [ANGW-1:0]      ang   [2];
  logic [ANGW-1:0]      ang_q [2];
  logic [ANGW-1:0]      ang_r [2];
  logic                 neg   [2];
  logic signed [CW-1:0] p_z_r [2];
  logic                 p_valid_r;
  side_t                p_side_r;

  always_comb begin
    ang[0] = d_quo[LN_T][NUMW][ANGW-1:0];
    ang[1] = d_quo[LN_P][NUMW][ANGW-1:0];
    for (int l = 0; l < 2; l++) begin
      ang_q[l] = ang[l] + 32'h40000000;
      neg[l]   = ang_q[l][ANGW-1];
      ang_r[l] = neg[l] ? (ang[l] ^ 32'h80000000) : ang[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= dv_r[NUMW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        p_z_r[l] <= CW'($signed(ang_r[l]));
      end
      p_side_r.clamped <= dclp_r[NUMW-1];
      p_side_r.neg_t   <= neg[0];
      p_side_r.neg_p   <= neg[1];
      p_side_r.u       <= d_quo[LN_U][NUMW][TEXW-1:0];
      p_side_r.v       <= d_quo[LN_V][NUMW][TEXW-1:0];
    end
  end

  // ---------------- CORDIC cell chain ----------------
  logic signed [CW-1:0] c_x [2][NC+1];
  logic signed [CW-1:0] c_y [2][NC+1];
  logic signed [CW-1:0] c_z [2][NC+1];

  for (genvar l = 0; l < 2; l++) begin : g_cl
    assign c_x[l][0] = $signed({{(CW-ANGW){1'b0}}, CORDIC_X0});
    assign c_y[l][0] = '0;
    assign c_z[l][0] = p_z_r[l];
    for (genvar s = 0; s < NC; s++) begin : g_cs
      uvsg_cordic_cell #(.STAGE(s)) u_cell (
        .clk (clk),
        .en  (adv),
        .x_i (c_x[l][s]),
        .y_i (c_y[l][s]),
        .z_i (c_z[l][s]),
        .x_o (c_x[l][s+1]),
        .y_o (c_y[l][s+1]),
        .z_o (c_z[l][s+1])
      );
    end
  end

  // CORDIC sideband
  logic [NC-1:0] cv_r;
  side_t         cs_r [NC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (adv) begin
      cv_r <= {cv_r[NC-2:0], p_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0] <= p_side_r;
      for (int i = 1; i < NC; i++) cs_r[i] <= cs_r[i-1];
    end
  end

  // ---------------- stage A: sign fix, single-term rounding ----------------
  side_t                c_side;
  logic signed [CW-1:0] st_w, ct_w, sp_w, cp_w;
  logic signed [32:0]   ny_s, tx_s, tz_s;
  logic signed [19:0]   ny_w, tx_w, tz_w;

  assign c_side = cs_r[NC-1];

  always_comb begin
    st_w = c_side.neg_t ? -c_y[0][NC] : c_y[0][NC];
    ct_w = c_side.neg_t ? -c_x[0][NC] : c_x[0][NC];
    sp_w = c_side.neg_p ? -c_y[1][NC] : c_y[1][NC];
    cp_w = c_side.neg_p ? -c_x[1][NC] : c_x[1][NC];
    ny_s = $signed(ct_w[32:0]) + 33'sh8000;
    tx_s = $signed(sp_w[32:0]) + 33'sh8000;
    tz_s = $signed(cp_w[32:0]) + 33'sh8000;
    ny_w = {{3{ny_s[32]}}, ny_s[32:16]};
    tx_w = -$signed({{3{tx_s[32]}}, tx_s[32:16]});
    tz_w = {{3{tz_s[32]}}, tz_s[32:16]};
  end

  logic                   a_valid_r;
  side_t                  a_side_r;
  logic signed [31:0]     a_st_r, a_sp_r, a_cp_r;
  logic signed [UNITW-1:0] a_ny_r, a_tx_r, a_tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= cv_r[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= c_side;
      a_st_r   <= st_w[31:0];
      a_sp_r   <= sp_w[31:0];
      a_cp_r   <= cp_w[31:0];
      a_ny_r   <= sat_unit(ny_w);
      a_tx_r   <= sat_unit(tx_w);
      a_tz_r   <= sat_unit(tz_w);
    end
  end

  // ---------------- stage B: sin(theta) products ----------------
  logic                    b_valid_r;
  side_t                   b_side_r;
  logic signed [63:0]      b_pnx_r, b_pnz_r;
  logic signed [UNITW-1:0] b_ny_r, b_tx_r, b_tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side_r <= a_side_r;
      b_pnx_r  <= a_st_r * a_cp_r;
      b_pnz_r  <= a_st_r * a_sp_r;
      b_ny_r   <= a_ny_r;
      b_tx_r   <= a_tx_r;
      b_tz_r   <= a_tz_r;
    end
  end

  // ---------------- stage C: round products to Q2.14 ----------------
  logic signed [64:0] rnx, rnz, snx, snz;

  always_comb begin
    rnx = $signed({b_pnx_r[63], b_pnx_r}) + $signed(65'h0_0000_2000_0000_0000);
    rnz = $signed({b_pnz_r[63], b_pnz_r}) + $signed(65'h0_0000_2000_0000_0000);
    snx = rnx >>> 46;
    snz = rnz >>> 46;
  end

  logic                    c_valid_r;
  side_t                   c_side_r;
  logic signed [UNITW-1:0] c_nx_r, c_ny_r, c_nz_r, c_tx_r, c_tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side_r <= b_side_r;
      c_nx_r   <= sat_unit(snx[19:0]);
      c_nz_r   <= sat_unit(snz[19:0]);
      c_ny_r   <= b_ny_r;
      c_tx_r   <= b_tx_r;
      c_tz_r   <= b_tz_r;
    end
  end

  // ---------------- output stage: scale by radius ----------------
  logic signed [32:0] px_m, py_m, pz_m;
  logic signed [33:0] px_s, py_s, pz_s;
  logic signed [RADW:0] rad_s;

  always_comb begin
    rad_s = $signed({1'b0, radius_r});
    px_m  = c_nx_r * rad_s;
    py_m  = c_ny_r * rad_s;
    pz_m  = c_nz_r * rad_s;
    px_s  = $signed({px_m[32], px_m}) + 34'sh2000;
    py_s  = $signed({py_m[32], py_m}) + 34'sh2000;
    pz_s  = $signed({pz_m[32], pz_m}) + 34'sh2000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid_r;
    end
  end

  logic signed [POSW-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic signed [UNITW-1:0] nx_r, ny_r, nz_r, tx_r, tz_r;
  logic [TEXW-1:0]         u_r, v_r;
  logic                    clp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r <= sat_pos(px_s[33:14]);
      pos_y_r <= sat_pos(py_s[33:14]);
      pos_z_r <= sat_pos(pz_s[33:14]);
      nx_r    <= c_nx_r;
      ny_r    <= c_ny_r;
      nz_r    <= c_nz_r;
      tx_r    <= c_tx_r;
      tz_r    <= c_tz_r;
      u_r     <= c_side_r.u;
      v_r     <= c_side_r.v;
      clp_r   <= c_side_r.clamped;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position_x = pos_x_r;
  assign out_position_y = pos_y_r;
  assign out_position_z = pos_z_r;
  assign out_normal_x   = nx_r;
  assign out_normal_y   = ny_r;
  assign out_normal_z   = nz_r;
  assign out_tangent_x  = tx_r;
  assign out_tangent_z  = tz_r;
  assign out_tex_u      = u_r;
  assign out_tex_v      = v_r;
  assign out_clamped    = clp_r;

endmodule

`default_nettype wire

### hdl/uvsg_div_cell.sv
// uvsg_div_cell: one restoring-division step, one quotient bit per cell.
// Depends on uvsg_pkg.
`default_nettype none

module uvsg_div_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [uvsg_pkg::REMW-1:0] divisor,
  input  logic [uvsg_pkg::REMW-1:0] rem_i,
  input  logic [uvsg_pkg::NUMW-1:0] num_i,
  input  logic [uvsg_pkg::NUMW-1:0] quo_i,
  output logic [uvsg_pkg::REMW-1:0] rem_o,
  output logic [uvsg_pkg::NUMW-1:0] num_o,
  output logic [uvsg_pkg::NUMW-1:0] quo_o
);
  import uvsg_pkg::*;

  logic [REMW:0]   trial;
  logic            ge;
  logic [REMW-1:0] rem_r;
  logic [NUMW-1:0] num_r;
  logic [NUMW-1:0] quo_r;

  // bring down the next numerator bit and try the subtract
  always_comb begin
    trial = {rem_i, num_i[NUMW-1]};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? REMW'(trial - {1'b0, divisor}) : trial[REMW-1:0];
      num_r <= {num_i[NUMW-2:0], 1'b0};
      quo_r <= {quo_i[NUMW-2:0], ge};
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

### hdl/uvsg_cordic_cell.sv
// uvsg_cordic_cell: one rotation-mode CORDIC micro-rotation, registered.
// Depends on uvsg_pkg (angle table).
`default_nettype none

module uvsg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [uvsg_pkg::CW-1:0] x_i,
  input  logic signed [uvsg_pkg::CW-1:0] y_i,
  input  logic signed [uvsg_pkg::CW-1:0] z_i,
  output logic signed [uvsg_pkg::CW-1:0] x_o,
  output logic signed [uvsg_pkg::CW-1:0] y_o,
  output logic signed [uvsg_pkg::CW-1:0] z_o
);
  import uvsg_pkg::*;

  logic signed [CW-1:0] xs, ys, at;
  logic signed [CW-1:0] x_r, y_r, z_r;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    at = $signed({{(CW-ANGW){1'b0}}, ATAN_BAM[STAGE]});
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[CW-1]) begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - at;
      end else begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + at;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

`default_nettype wire

### hdl/uvsg_checker.sv
// uvsg_checker: port-level assertions for uv_sphere_vertex_generator, with bind.
// Depends on uvsg_pkg.
`default_nettype none

module uvsg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_we,
  input logic [uvsg_pkg::CFG_IDXW-1:0]     cfg_index,
  input logic [uvsg_pkg::CFGW-1:0]         cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [uvsg_pkg::ROWW-1:0]         in_stack_row,
  input logic [uvsg_pkg::COLW-1:0]         in_slice_column,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [uvsg_pkg::POSW-1:0]  out_position_x,
  input logic signed [uvsg_pkg::POSW-1:0]  out_position_y,
  input logic signed [uvsg_pkg::POSW-1:0]  out_position_z,
  input logic signed [uvsg_pkg::UNITW-1:0] out_normal_x,
  input logic signed [uvsg_pkg::UNITW-1:0] out_normal_y,
  input logic signed [uvsg_pkg::UNITW-1:0] out_normal_z,
  input logic signed [uvsg_pkg::UNITW-1:0] out_tangent_x,
  input logic signed [uvsg_pkg::UNITW-1:0] out_tangent_z,
  input logic [uvsg_pkg::TEXW-1:0]         out_tex_u,
  input logic [uvsg_pkg::TEXW-1:0]         out_tex_v,
  input logic                              out_clamped
);
  import uvsg_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload (tex u and normal y are checked)
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_tex_u) && $stable(out_normal_y))
    else $error("result payload changed while stalled");

  // input only backs up when a result is waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result");

  // normal y and tangent z stay within +-1.0
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normal_y <= 16'sd16384) && (out_normal_y >= -16'sd16384) &&
                  (out_tangent_z <= 16'sd16384) && (out_tangent_z >= -16'sd16384))
    else $error("unit component out of range");

  // texture coordinates stay within [0, 1]
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_u <= 17'd65536) && (out_tex_v <= 17'd65536))
    else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator uvsg_checker u_uvsg_checker (.*);

`default_nettype wire
